### hdl/vcsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcsg_pkg: shared types and constants of the velocity command safety gate
// Holds the action and cause codes, the register map, reset values and the
// configuration bundle passed from the register file to the core.
// ----------------------------------------------------------------------------
package vcsg_pkg;

    // Default widths of the configurable datapath.
    localparam int VEL_BITS_DEF = 16;
    localparam int AGE_BITS_DEF = 17;
    localparam int SEQ_BITS_DEF = 32;

    // Fixed field widths.
    localparam int ACTION_W   = 2;
    localparam int CAUSE_W    = 3;
    localparam int LIMIT_W    = 15;
    localparam int LEVEL_W    = 13;
    localparam int TIMEOUT_W  = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // A full battery reads 1.0 in Q1.12.
    localparam logic [LEVEL_W-1:0] BATTERY_FULL = LEVEL_W'(4096);

    // Register reset values.
    localparam logic                 RST_GATE_ENABLE      = 1'b0;
    localparam logic                 RST_BATTERY_REQUIRED = 1'b1;
    localparam logic [LIMIT_W-1:0]   RST_LIMIT_FORWARD    = LIMIT_W'(410);
    localparam logic [LIMIT_W-1:0]   RST_LIMIT_LATERAL    = LIMIT_W'(205);
    localparam logic [LIMIT_W-1:0]   RST_LIMIT_YAW        = LIMIT_W'(819);
    localparam logic [LEVEL_W-1:0]   RST_BATTERY_FLOOR    = LEVEL_W'(819);
    localparam logic [TIMEOUT_W-1:0] RST_BATTERY_TIMEOUT  = TIMEOUT_W'(1000);
    localparam logic [TIMEOUT_W-1:0] RST_COMMAND_TIMEOUT  = TIMEOUT_W'(300);

    typedef enum logic [ACTION_W-1:0] {
        ACT_COMMAND,
        ACT_BATTERY,
        ACT_TICK,
        ACT_SHUTDOWN
    } t_action;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_FORWARDED,
        CAUSE_BLOCKED,
        CAUSE_LOW_BATTERY,
        CAUSE_WATCHDOG,
        CAUSE_SHUTDOWN
    } t_cause;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GATE_ENABLE,
        REG_BATTERY_REQUIRED,
        REG_LIMIT_FORWARD,
        REG_LIMIT_LATERAL,
        REG_LIMIT_YAW,
        REG_BATTERY_FLOOR,
        REG_BATTERY_TIMEOUT,
        REG_COMMAND_TIMEOUT
    } t_reg_index;

    typedef struct packed {
        logic                 gate_enable;
        logic                 battery_required;
        logic [LIMIT_W-1:0]   limit_forward;
        logic [LIMIT_W-1:0]   limit_lateral;
        logic [LIMIT_W-1:0]   limit_yaw;
        logic [LEVEL_W-1:0]   battery_floor;
        logic [TIMEOUT_W-1:0] battery_timeout;
        logic [TIMEOUT_W-1:0] command_timeout;
    } t_cfg;

endpackage
`default_nettype wire

### hdl/vcsg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcsg_if: valid/ready channels of the velocity command safety gate
// The event channel carries commands, battery reports, ticks and shutdowns;
// the result channel carries the packets sent to the motor controller.
// ----------------------------------------------------------------------------
interface vcsg_evt_if
    import vcsg_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VEL_BITS-1:0] cmd_forward;
    logic [VEL_BITS-1:0] cmd_lateral;
    logic [VEL_BITS-1:0] cmd_yaw;
    logic                forward_finite;
    logic                lateral_finite;
    logic                yaw_finite;
    logic [LEVEL_W-1:0]  battery_level;
    logic                battery_finite;

    modport source (
        output valid, action, cmd_forward, cmd_lateral, cmd_yaw,
               forward_finite, lateral_finite, yaw_finite,
               battery_level, battery_finite,
        input  ready
    );

    modport sink (
        input  valid, action, cmd_forward, cmd_lateral, cmd_yaw,
               forward_finite, lateral_finite, yaw_finite,
               battery_level, battery_finite,
        output ready
    );
endinterface

interface vcsg_pkt_if
    import vcsg_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [VEL_BITS-1:0] out_forward;
    logic [VEL_BITS-1:0] out_lateral;
    logic [VEL_BITS-1:0] out_yaw;
    logic [SEQ_BITS-1:0] packet_sequence;
    logic [CAUSE_W-1:0]  send_cause;

    modport source (
        output valid, out_forward, out_lateral, out_yaw, packet_sequence, send_cause,
        input  ready
    );

    modport sink (
        input  valid, out_forward, out_lateral, out_yaw, packet_sequence, send_cause,
        output ready
    );
endinterface
`default_nettype wire

### hdl/velocity_command_safety_gate_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_command_safety_gate_core: safety gate for three-axis velocity
// Clamps commands, tracks battery freshness and a command watchdog, and sends
// zero or the clamped command to the motor controller with a sequence number.
// ----------------------------------------------------------------------------
// The gate accepts one event beat in every clock cycle while its output
// buffer has room; the whole decision for an event (clamp, freshness checks,
// age counters) is combinational logic at acceptance. Any packet it causes
// appears on the result channel on the next cycle when no earlier packet is
// waiting, or else queues behind the waiting one. Results pass through a
// two-entry output buffer, so the event side stays ready while one packet
// waits; ready falls only when both buffer entries hold packets that have
// not been taken. Ticks and good battery reports usually cause no packet.
// Registers may be written over APB only while no event is in flight.
module velocity_command_safety_gate_core
    import vcsg_pkg::*;
#(
    parameter int VEL_BITS = VEL_BITS_DEF,
    parameter int AGE_BITS = AGE_BITS_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    vcsg_evt_if.sink                   i_evt,
    vcsg_pkt_if.source                 o_pkt,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CW     = (VEL_BITS > LIMIT_W ? VEL_BITS : LIMIT_W) + 2;
    localparam int AW     = (AGE_BITS > TIMEOUT_W ? AGE_BITS : TIMEOUT_W);
    localparam int DATA_W = 3 * VEL_BITS + SEQ_BITS + CAUSE_W;

    t_cfg                w_cfg;
    t_action             w_action;
    t_cause              w_cause;
    logic                w_accept;
    logic                w_emit;
    logic                w_space;
    logic                w_fresh_now;
    logic                w_fresh_tick;
    logic                w_level_good;
    logic [VEL_BITS-1:0] w_clamp_f;
    logic [VEL_BITS-1:0] w_clamp_l;
    logic [VEL_BITS-1:0] w_clamp_y;
    logic [VEL_BITS-1:0] w_send_f;
    logic [VEL_BITS-1:0] w_send_l;
    logic [VEL_BITS-1:0] w_send_y;
    logic [AGE_BITS-1:0] w_bat_age_inc;
    logic [AGE_BITS-1:0] w_cmd_age_inc;
    logic [DATA_W-1:0]   w_pkt_data;

    logic                r_battery_good;
    logic                r_battery_seen;
    logic                r_motion_active;
    logic [AGE_BITS-1:0] r_battery_age;
    logic [AGE_BITS-1:0] r_command_age;
    logic [SEQ_BITS-1:0] r_next_seq;
    logic                n_battery_good;
    logic                n_battery_seen;
    logic                n_motion_active;
    logic [AGE_BITS-1:0] n_battery_age;
    logic [AGE_BITS-1:0] n_command_age;
    logic [SEQ_BITS-1:0] n_next_seq;

    // Symmetric clamp of one axis; a non-finite axis reads as zero.
    function automatic logic [VEL_BITS-1:0] clamp_axis(
        input logic [VEL_BITS-1:0] raw,
        input logic                finite,
        input logic [LIMIT_W-1:0]  lim
    );
        logic signed [CW-1:0] v;
        logic signed [CW-1:0] l;
        v = {{(CW-VEL_BITS){raw[VEL_BITS-1]}}, raw};
        l = {{(CW-LIMIT_W){1'b0}}, lim};
        if (!finite) begin
            v = '0;
        end
        if (v > l) begin
            v = l;
        end
        if (v < -l) begin
            v = -l;
        end
        return v[VEL_BITS-1:0];
    endfunction

    // Register file.
    vcsg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign i_evt.ready = w_space;
    assign w_accept    = i_evt.valid && w_space;
    assign w_action    = t_action'(i_evt.action);

    // Per-axis clamps.
    assign w_clamp_f = clamp_axis(i_evt.cmd_forward, i_evt.forward_finite, w_cfg.limit_forward);
    assign w_clamp_l = clamp_axis(i_evt.cmd_lateral, i_evt.lateral_finite, w_cfg.limit_lateral);
    assign w_clamp_y = clamp_axis(i_evt.cmd_yaw, i_evt.yaw_finite, w_cfg.limit_yaw);

    // Saturating ages as a tick would leave them.
    assign w_bat_age_inc = (&r_battery_age) ? r_battery_age : r_battery_age + 1'b1;
    assign w_cmd_age_inc = (&r_command_age) ? r_command_age : r_command_age + 1'b1;

    // Battery freshness before and after a tick, and the verdict on a report.
    assign w_fresh_now  = r_battery_good && r_battery_seen &&
                          (AW'(r_battery_age) <= AW'(w_cfg.battery_timeout));
    assign w_fresh_tick = r_battery_good && r_battery_seen &&
                          (AW'(w_bat_age_inc) <= AW'(w_cfg.battery_timeout));
    assign w_level_good = i_evt.battery_finite &&
                          (i_evt.battery_level >= w_cfg.battery_floor) &&
                          (i_evt.battery_level <= BATTERY_FULL);

    // Event decision and next state.
    always_comb begin
        n_battery_good  = r_battery_good;
        n_battery_seen  = r_battery_seen;
        n_motion_active = r_motion_active;
        n_battery_age   = r_battery_age;
        n_command_age   = r_command_age;
        n_next_seq      = r_next_seq;
        w_emit          = 1'b0;
        w_cause         = CAUSE_SHUTDOWN;
        w_send_f        = '0;
        w_send_l        = '0;
        w_send_y        = '0;
        case (w_action)
            ACT_COMMAND: begin
                n_command_age = '0;
                w_emit        = 1'b1;
                if (!w_cfg.gate_enable || (w_cfg.battery_required && !w_fresh_now)) begin
                    w_cause = CAUSE_BLOCKED;
                end else begin
                    w_cause  = CAUSE_FORWARDED;
                    w_send_f = w_clamp_f;
                    w_send_l = w_clamp_l;
                    w_send_y = w_clamp_y;
                end
            end
            ACT_BATTERY: begin
                n_battery_good = w_level_good;
                n_battery_seen = 1'b1;
                n_battery_age  = '0;
                w_cause        = CAUSE_LOW_BATTERY;
                w_emit         = w_cfg.battery_required && !w_level_good && r_motion_active;
            end
            ACT_TICK: begin
                n_battery_age = w_bat_age_inc;
                n_command_age = w_cmd_age_inc;
                w_cause       = CAUSE_WATCHDOG;
                w_emit        = r_motion_active &&
                                ((AW'(w_cmd_age_inc) > AW'(w_cfg.command_timeout)) ||
                                 (w_cfg.battery_required && !w_fresh_tick));
            end
            ACT_SHUTDOWN: begin
                w_cause = CAUSE_SHUTDOWN;
                w_emit  = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
        if (w_emit) begin
            n_motion_active = (|w_send_f) || (|w_send_l) || (|w_send_y);
            n_next_seq      = r_next_seq + 1'b1;
        end
    end

    // Gate state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery_good  <= 1'b0;
            r_battery_seen  <= 1'b0;
            r_motion_active <= 1'b0;
            r_battery_age   <= '1;
            r_command_age   <= '1;
            r_next_seq      <= '0;
        end else if (w_accept) begin
            r_battery_good  <= n_battery_good;
            r_battery_seen  <= n_battery_seen;
            r_motion_active <= n_motion_active;
            r_battery_age   <= n_battery_age;
            r_command_age   <= n_command_age;
            r_next_seq      <= n_next_seq;
        end
    end

    // Result buffer.
    assign w_pkt_data = {w_send_f, w_send_l, w_send_y, r_next_seq, w_cause};

    vcsg_out_buf #(
        .DATA_W (DATA_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_emit),
        .i_data  (w_pkt_data),
        .o_space (w_space),
        .o_valid (o_pkt.valid),
        .i_ready (o_pkt.ready),
        .o_data  ({o_pkt.out_forward, o_pkt.out_lateral, o_pkt.out_yaw,
                   o_pkt.packet_sequence, o_pkt.send_cause})
    );

    // A shutdown always leaves a packet waiting on the next cycle.
    a_shutdown_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_SHUTDOWN)) |=> o_pkt.valid)
        else $error("shutdown did not produce a packet");

    // The sequence number advances by one for each packet sent.
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit) |=> (r_next_seq == SEQ_BITS'($past(r_next_seq) + 1'b1)))
        else $error("sequence number did not advance on a send");

    // Without a send the sequence number holds.
    a_seq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && w_emit) |=> $stable(r_next_seq))
        else $error("sequence number moved without a send");

    // A command restarts the watchdog.
    a_cmd_age_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_COMMAND)) |=> (r_command_age == '0))
        else $error("command age not cleared by a command");

    // Motion stays off after any packet other than a forwarded one.
    a_motion_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit && (w_cause != CAUSE_FORWARDED)) |=> !r_motion_active)
        else $error("motion flagged after a zero packet");

endmodule
`default_nettype wire

### hdl/vcsg_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcsg_cfg_regs: APB register file of the velocity command safety gate
// Eight registers at word addresses; writes complete in the access phase,
// reads return the stored value zero-extended to the bus width.
// ----------------------------------------------------------------------------
module vcsg_cfg_regs
    import vcsg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_index = t_reg_index'(paddr[APB_ADDR_W-1:2]);
    assign w_write = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_enable      <= RST_GATE_ENABLE;
            r_cfg.battery_required <= RST_BATTERY_REQUIRED;
            r_cfg.limit_forward    <= RST_LIMIT_FORWARD;
            r_cfg.limit_lateral    <= RST_LIMIT_LATERAL;
            r_cfg.limit_yaw        <= RST_LIMIT_YAW;
            r_cfg.battery_floor    <= RST_BATTERY_FLOOR;
            r_cfg.battery_timeout  <= RST_BATTERY_TIMEOUT;
            r_cfg.command_timeout  <= RST_COMMAND_TIMEOUT;
        end else if (w_write) begin
            case (w_index)
                REG_GATE_ENABLE:      r_cfg.gate_enable      <= pwdata[0];
                REG_BATTERY_REQUIRED: r_cfg.battery_required <= pwdata[0];
                REG_LIMIT_FORWARD:    r_cfg.limit_forward    <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_LATERAL:    r_cfg.limit_lateral    <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_YAW:        r_cfg.limit_yaw        <= pwdata[LIMIT_W-1:0];
                REG_BATTERY_FLOOR:    r_cfg.battery_floor    <= pwdata[LEVEL_W-1:0];
                REG_BATTERY_TIMEOUT:  r_cfg.battery_timeout  <= pwdata[TIMEOUT_W-1:0];
                REG_COMMAND_TIMEOUT:  r_cfg.command_timeout  <= pwdata[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_index)
            REG_GATE_ENABLE:      prdata = APB_DATA_W'(r_cfg.gate_enable);
            REG_BATTERY_REQUIRED: prdata = APB_DATA_W'(r_cfg.battery_required);
            REG_LIMIT_FORWARD:    prdata = APB_DATA_W'(r_cfg.limit_forward);
            REG_LIMIT_LATERAL:    prdata = APB_DATA_W'(r_cfg.limit_lateral);
            REG_LIMIT_YAW:        prdata = APB_DATA_W'(r_cfg.limit_yaw);
            REG_BATTERY_FLOOR:    prdata = APB_DATA_W'(r_cfg.battery_floor);
            REG_BATTERY_TIMEOUT:  prdata = APB_DATA_W'(r_cfg.battery_timeout);
            REG_COMMAND_TIMEOUT:  prdata = APB_DATA_W'(r_cfg.command_timeout);
            default:              prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### hdl/vcsg_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vcsg_out_buf: two-entry result buffer
// A head register drives the output and a skid register catches a beat that
// arrives while the head is stalled, so the input side keeps flowing.
// ----------------------------------------------------------------------------
module vcsg_out_buf
    import vcsg_pkg::*;
#(
    parameter int DATA_W = 3 * VEL_BITS_DEF + SEQ_BITS_DEF + CAUSE_W
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_data
);

    logic              r_head_valid;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_head;
    logic [DATA_W-1:0] r_skid;
    logic              w_pop;

    // Room is left while the skid entry is empty.
    assign o_space = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;
    assign w_pop   = r_head_valid && i_ready;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_head_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid <= i_data;
            end else begin
                r_head <= i_data;
            end
        end
    end

endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the velocity command safety gate
// Drives command, battery, tick and shutdown beats into the gate, predicts
// every packet from a behavioural copy of the gate's state and registers, and
// compares each packet taken from the result channel against the oldest
// prediction. Registers are loaded over APB between phases while the gate is
// idle, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import vcsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      VEL_W         = VEL_BITS_DEF;
    localparam int      AGE_W         = AGE_BITS_DEF;
    localparam int      SEQ_W         = SEQ_BITS_DEF;
    localparam int      VEL_MAX       = 2 ** (VEL_W - 1) - 1;
    localparam int      VEL_MIN       = -(2 ** (VEL_W - 1));
    localparam realtime HALF_PERIOD   = 4.0;
    localparam int      RESET_CYCLES  = 12;
    localparam int      SETTLE_CYCLES = 4;
    localparam int      TAIL_CYCLES   = 16;
    localparam int      PHASE_ITEMS   = 68;
    localparam int      PRINT_CAP     = 40;
    localparam int      CYCLE_LIMIT   = 400000;

    localparam logic [AGE_W-1:0] AGE_SAT = '1;

    typedef enum {
        PH_GUARDED,
        PH_OPEN,
        PH_CLOSED,
        PH_ZERO_LIMIT,
        PH_HIGH_FLOOR,
        PH_EDGE,
        PH_MAX,
        PH_WILD
    } t_phase;

    typedef struct {
        t_action                 action;
        logic signed [VEL_W-1:0] forward;
        logic signed [VEL_W-1:0] lateral;
        logic signed [VEL_W-1:0] yaw;
        logic                    forward_finite;
        logic                    lateral_finite;
        logic                    yaw_finite;
        logic [LEVEL_W-1:0]      level;
        logic                    level_finite;
    } t_gate_event;

    typedef struct {
        logic signed [VEL_W-1:0] forward;
        logic signed [VEL_W-1:0] lateral;
        logic signed [VEL_W-1:0] yaw;
        logic [SEQ_W-1:0]        seq_num;
        t_cause                  cause;
    } t_gate_packet;

    // Behavioural copy of the gate: registers, battery and watchdog state, and
    // the packets still owed by the gate, oldest first.
    class gate_packet_scoreboard;
        t_cfg             settings;
        logic             battery_good;
        logic             battery_seen;
        logic             motion_active;
        logic [AGE_W-1:0] battery_age;
        logic [AGE_W-1:0] command_age;
        logic [SEQ_W-1:0] next_seq;
        t_gate_packet     expected_packets[$];
        int unsigned      failures;

        function new();
            settings.gate_enable      = RST_GATE_ENABLE;
            settings.battery_required = RST_BATTERY_REQUIRED;
            settings.limit_forward    = RST_LIMIT_FORWARD;
            settings.limit_lateral    = RST_LIMIT_LATERAL;
            settings.limit_yaw        = RST_LIMIT_YAW;
            settings.battery_floor    = RST_BATTERY_FLOOR;
            settings.battery_timeout  = RST_BATTERY_TIMEOUT;
            settings.command_timeout  = RST_COMMAND_TIMEOUT;
            battery_good  = 1'b0;
            battery_seen  = 1'b0;
            motion_active = 1'b0;
            battery_age   = AGE_SAT;
            command_age   = AGE_SAT;
            next_seq      = '0;
            failures      = 0;
        endfunction

        function int pending();
            return expected_packets.size();
        endfunction

        function void set_register(t_reg_index idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_GATE_ENABLE:      settings.gate_enable      = value[0];
                REG_BATTERY_REQUIRED: settings.battery_required = value[0];
                REG_LIMIT_FORWARD:    settings.limit_forward    = value[LIMIT_W-1:0];
                REG_LIMIT_LATERAL:    settings.limit_lateral    = value[LIMIT_W-1:0];
                REG_LIMIT_YAW:        settings.limit_yaw        = value[LIMIT_W-1:0];
                REG_BATTERY_FLOOR:    settings.battery_floor    = value[LEVEL_W-1:0];
                REG_BATTERY_TIMEOUT:  settings.battery_timeout  = value[TIMEOUT_W-1:0];
                REG_COMMAND_TIMEOUT:  settings.command_timeout  = value[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        endfunction

        // A non-finite axis is zero; otherwise the value is held within
        // plus or minus the limit.
        function logic signed [VEL_W-1:0] limit_axis(logic signed [VEL_W-1:0] raw,
                                                     logic finite,
                                                     logic [LIMIT_W-1:0] lim);
            int value;
            int bound;
            value = raw;
            bound = lim;
            if (!finite) return '0;
            if (value > bound) value = bound;
            if (value < -bound) value = -bound;
            return value[VEL_W-1:0];
        endfunction

        function logic battery_current();
            return battery_good && battery_seen && (battery_age <= settings.battery_timeout);
        endfunction

        // Every packet takes the next sequence number, and motion counts as
        // active exactly when the packet carries a nonzero axis.
        function void queue_packet(logic signed [VEL_W-1:0] f, logic signed [VEL_W-1:0] l,
                                   logic signed [VEL_W-1:0] y, t_cause cause);
            t_gate_packet p;
            p.forward = f;
            p.lateral = l;
            p.yaw     = y;
            p.seq_num = next_seq;
            p.cause   = cause;
            next_seq  = next_seq + 1'b1;
            motion_active = (f != 0) || (l != 0) || (y != 0);
            expected_packets.push_back(p);
        endfunction

        function void note_event(t_gate_event ev);
            logic signed [VEL_W-1:0] f;
            logic signed [VEL_W-1:0] l;
            logic signed [VEL_W-1:0] y;
            case (ev.action)
                ACT_COMMAND: begin
                    f = limit_axis(ev.forward, ev.forward_finite, settings.limit_forward);
                    l = limit_axis(ev.lateral, ev.lateral_finite, settings.limit_lateral);
                    y = limit_axis(ev.yaw, ev.yaw_finite, settings.limit_yaw);
                    command_age = '0;
                    if (!settings.gate_enable ||
                        (settings.battery_required && !battery_current())) begin
                        queue_packet('0, '0, '0, CAUSE_BLOCKED);
                    end else begin
                        queue_packet(f, l, y, CAUSE_FORWARDED);
                    end
                end
                ACT_BATTERY: begin
                    battery_good = ev.level_finite && (ev.level >= settings.battery_floor)
                                   && (ev.level <= BATTERY_FULL);
                    battery_seen = 1'b1;
                    battery_age  = '0;
                    if (settings.battery_required && !battery_good && motion_active) begin
                        queue_packet('0, '0, '0, CAUSE_LOW_BATTERY);
                    end
                end
                ACT_TICK: begin
                    if (battery_age != AGE_SAT) battery_age = battery_age + 1'b1;
                    if (command_age != AGE_SAT) command_age = command_age + 1'b1;
                    if (motion_active && ((command_age > settings.command_timeout)
                        || (settings.battery_required && !battery_current()))) begin
                        queue_packet('0, '0, '0, CAUSE_WATCHDOG);
                    end
                end
                ACT_SHUTDOWN: begin
                    queue_packet('0, '0, '0, CAUSE_SHUTDOWN);
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [SEQ_W-1:0] seq, logic [31:0] got,
                             logic [31:0] want);
            failures++;
            if (failures <= PRINT_CAP) begin
                $display("[%0t] packet %0d %s: got 0x%0h, expected 0x%0h",
                         $time, seq, what, got, want);
            end
        endtask

        task check_packet(t_gate_packet got);
            t_gate_packet want;
            if (expected_packets.size() == 0) begin
                report_mismatch("arrived with nothing expected", got.seq_num, got.cause, '0);
                return;
            end
            want = expected_packets.pop_front();
            if (got.forward !== want.forward)
                report_mismatch("out_forward", want.seq_num, got.forward, want.forward);
            if (got.lateral !== want.lateral)
                report_mismatch("out_lateral", want.seq_num, got.lateral, want.lateral);
            if (got.yaw !== want.yaw)
                report_mismatch("out_yaw", want.seq_num, got.yaw, want.yaw);
            if (got.seq_num !== want.seq_num)
                report_mismatch("packet_sequence", want.seq_num, got.seq_num, want.seq_num);
            if (got.cause !== want.cause)
                report_mismatch("send_cause", want.seq_num, got.cause, want.cause);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    sender_steady;
    bit                    sink_steady;
    int unsigned           cycle_count;
    gate_packet_scoreboard sb;

    vcsg_evt_if evt ();
    vcsg_pkt_if pkt ();

    velocity_command_safety_gate_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_pkt   (pkt),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Gap before an event beat: mostly none or short, now and then long.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (sender_steady || roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Random content in every field, so that fields the action ignores toggle too.
    function automatic t_gate_event noise_event(t_action act);
        t_gate_event ev;
        ev.action         = act;
        ev.forward        = VEL_W'($urandom);
        ev.lateral        = VEL_W'($urandom);
        ev.yaw            = VEL_W'($urandom);
        ev.forward_finite = 1'($urandom);
        ev.lateral_finite = 1'($urandom);
        ev.yaw_finite     = 1'($urandom);
        ev.level          = LEVEL_W'($urandom);
        ev.level_finite   = 1'($urandom);
        return ev;
    endfunction

    function automatic t_gate_event command_item(int f, int l, int y, bit [2:0] finite);
        t_gate_event ev;
        ev = noise_event(ACT_COMMAND);
        ev.forward        = f[VEL_W-1:0];
        ev.lateral        = l[VEL_W-1:0];
        ev.yaw            = y[VEL_W-1:0];
        ev.forward_finite = finite[2];
        ev.lateral_finite = finite[1];
        ev.yaw_finite     = finite[0];
        return ev;
    endfunction

    function automatic t_gate_event battery_item(int level, bit finite);
        t_gate_event ev;
        ev = noise_event(ACT_BATTERY);
        ev.level        = level[LEVEL_W-1:0];
        ev.level_finite = finite;
        return ev;
    endfunction

    // Axis values cluster around the limit, with the extremes of the field
    // and fully random values mixed in.
    function automatic int axis_value(int lim);
        int pick;
        int v;
        pick = $urandom_range(5, 0);
        if (pick == 0) begin
            v = int'($urandom_range(VEL_MAX - VEL_MIN, 0)) + VEL_MIN;
        end else if (pick == 1) begin
            case ($urandom_range(6, 0))
                0:       v = VEL_MAX;
                1:       v = VEL_MIN;
                2:       v = 0;
                3:       v = lim;
                4:       v = -lim;
                5:       v = lim + 1;
                default: v = -lim - 1;
            endcase
        end else begin
            v = int'($urandom_range(2 * lim + 2, 0)) - (lim + 1);
        end
        if (v > VEL_MAX) v = VEL_MAX;
        if (v < VEL_MIN) v = VEL_MIN;
        return v;
    endfunction

    function automatic t_gate_event command_event(t_cfg c);
        bit [2:0] finite;
        finite[2] = ($urandom_range(9, 0) != 0);
        finite[1] = ($urandom_range(9, 0) != 0);
        finite[0] = ($urandom_range(9, 0) != 0);
        return command_item(axis_value(c.limit_forward), axis_value(c.limit_lateral),
                            axis_value(c.limit_yaw), finite);
    endfunction

    // Mostly good levels when the floor allows one, otherwise the edges of
    // the good range and random levels.
    function automatic t_gate_event battery_event(t_cfg c);
        int floor_lvl;
        int level;
        floor_lvl = c.battery_floor;
        if ($urandom_range(9, 0) < 7 && floor_lvl <= int'(BATTERY_FULL)) begin
            level = $urandom_range(int'(BATTERY_FULL), floor_lvl);
        end else begin
            case ($urandom_range(4, 0))
                0:       level = floor_lvl - 1;
                1:       level = int'(BATTERY_FULL) + 1;
                2:       level = 2 ** LEVEL_W - 1;
                3:       level = 0;
                default: level = $urandom_range(2 ** LEVEL_W - 1, 0);
            endcase
        end
        return battery_item(level, $urandom_range(9, 0) != 0);
    endfunction

    function automatic t_cfg phase_settings(t_phase p);
        t_cfg c;
        c.gate_enable      = 1'b1;
        c.battery_required = 1'b1;
        c.limit_forward    = LIMIT_W'($urandom_range(4096, 64));
        c.limit_lateral    = LIMIT_W'($urandom_range(4096, 64));
        c.limit_yaw        = LIMIT_W'($urandom_range(4096, 64));
        c.battery_floor    = RST_BATTERY_FLOOR;
        c.battery_timeout  = TIMEOUT_W'($urandom_range(20, 4));
        c.command_timeout  = TIMEOUT_W'($urandom_range(10, 1));
        case (p)
            PH_GUARDED: begin
                // Battery-gated forwarding with the defaults' floor.
            end
            PH_OPEN: begin
                c.battery_required = 1'b0;
                c.limit_forward    = '1;
                c.limit_lateral    = '1;
                c.limit_yaw        = '1;
                c.battery_floor    = '0;
            end
            PH_CLOSED: begin
                c.gate_enable      = 1'b0;
                c.battery_required = 1'($urandom);
                c.battery_floor    = LEVEL_W'($urandom_range(int'(BATTERY_FULL), 0));
            end
            PH_ZERO_LIMIT: begin
                c.battery_required = 1'b0;
                c.limit_forward    = '0;
                c.limit_lateral    = LIMIT_W'(1);
                c.limit_yaw        = LIMIT_W'($urandom_range(3, 0));
                c.battery_floor    = LEVEL_W'($urandom_range(2 ** LEVEL_W - 1, 4097));
            end
            PH_HIGH_FLOOR: begin
                c.battery_floor    = LEVEL_W'($urandom_range(2 ** LEVEL_W - 1, 4097));
            end
            PH_EDGE: begin
                c.limit_forward    = LIMIT_W'(1);
                c.limit_lateral    = LIMIT_W'(1);
                c.limit_yaw        = LIMIT_W'(1);
                c.battery_floor    = BATTERY_FULL;
                c.battery_timeout  = '0;
                c.command_timeout  = '0;
            end
            PH_MAX: begin
                c.limit_forward    = '1;
                c.limit_lateral    = '1;
                c.limit_yaw        = '1;
                c.battery_floor    = '0;
                c.battery_timeout  = '1;
                c.command_timeout  = '1;
            end
            PH_WILD: begin
                c.gate_enable      = 1'($urandom);
                c.battery_required = 1'($urandom);
                c.limit_forward    = LIMIT_W'($urandom);
                c.limit_lateral    = LIMIT_W'($urandom);
                c.limit_yaw        = LIMIT_W'($urandom);
                c.battery_floor    = LEVEL_W'($urandom);
                if ($urandom_range(1, 0) == 0) c.battery_timeout = TIMEOUT_W'($urandom);
                if ($urandom_range(1, 0) == 0) c.command_timeout = TIMEOUT_W'($urandom);
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // One event beat: optional gap, then valid held until the gate takes it.
    task automatic push_event(t_gate_event ev);
        int gap;
        gap = idle_gap();
        if (gap != 0) begin
            evt.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        evt.action         = ev.action;
        evt.cmd_forward    = ev.forward;
        evt.cmd_lateral    = ev.lateral;
        evt.cmd_yaw        = ev.yaw;
        evt.forward_finite = ev.forward_finite;
        evt.lateral_finite = ev.lateral_finite;
        evt.yaw_finite     = ev.yaw_finite;
        evt.battery_level  = ev.level;
        evt.battery_finite = ev.level_finite;
        evt.valid          = 1'b1;
        do @(posedge i_clk); while (!evt.ready);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every owed packet; the extra cycles cover an
    // event that is still in flight but owes no packet.
    task automatic drain_events();
        evt.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(t_reg_index idx, logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(t_cfg c);
        drain_events();
        write_register(REG_GATE_ENABLE, APB_DATA_W'(c.gate_enable));
        write_register(REG_BATTERY_REQUIRED, APB_DATA_W'(c.battery_required));
        write_register(REG_LIMIT_FORWARD, APB_DATA_W'(c.limit_forward));
        write_register(REG_LIMIT_LATERAL, APB_DATA_W'(c.limit_lateral));
        write_register(REG_LIMIT_YAW, APB_DATA_W'(c.limit_yaw));
        write_register(REG_BATTERY_FLOOR, APB_DATA_W'(c.battery_floor));
        write_register(REG_BATTERY_TIMEOUT, APB_DATA_W'(c.battery_timeout));
        write_register(REG_COMMAND_TIMEOUT, APB_DATA_W'(c.command_timeout));
    endtask

    // A phase: load a setting, then mostly sessions of battery reports,
    // commands and runs of ticks, with shutdowns and raw noise mixed in. Once
    // per phase the sender holds off until the gate has caught up.
    task automatic run_phase(t_phase p);
        t_cfg c;
        int   sent;
        int   drain_at;
        int   roll;
        int   burst;
        bit   drained;
        c = phase_settings(p);
        apply_settings(c);
        sender_steady = ($urandom_range(3, 0) == 0);
        sink_steady   = ($urandom_range(3, 0) == 0);
        sent     = 0;
        drained  = 1'b0;
        drain_at = $urandom_range(3 * PHASE_ITEMS / 4, PHASE_ITEMS / 4);
        while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(99, 0);
            if (roll < 40) begin
                push_event(command_event(c));
                sent++;
            end else if (roll < 58) begin
                push_event(battery_event(c));
                sent++;
            end else if (roll < 84) begin
                burst = $urandom_range(12, 1);
                repeat (burst) push_event(noise_event(ACT_TICK));
                sent += burst;
            end else if (roll < 92) begin
                push_event(noise_event(ACT_SHUTDOWN));
                sent++;
            end else begin
                push_event(noise_event(t_action'($urandom_range(3, 0))));
                sent++;
            end
            if (!drained && sent >= drain_at) begin
                drain_events();
                drained       = 1'b1;
                sender_steady = !sender_steady;
                sink_steady   = !sink_steady;
            end
        end
    endtask

    // Result-side readiness: bursts of ready with short and occasional long stalls.
    initial begin : packet_sink
        int hold;
        int roll;
        pkt.ready = 1'b0;
        hold      = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (sink_steady) begin
                pkt.ready = 1'b1;
            end else begin
                roll = $urandom_range(99, 0);
                if (roll < 55) begin
                    pkt.ready = 1'b1;
                    hold      = $urandom_range(11, 0);
                end else if (roll < 85) begin
                    pkt.ready = 1'b0;
                    hold      = $urandom_range(2, 0);
                end else if (roll < 97) begin
                    pkt.ready = 1'b0;
                    hold      = $urandom_range(11, 3);
                end else begin
                    pkt.ready = 1'b0;
                    hold      = $urandom_range(49, 19);
                end
            end
        end
    end

    // Beats on both channels are taken at the rising edge; a packet always
    // belongs to an event accepted on an earlier edge.
    always @(posedge i_clk) begin : beat_monitor
        t_gate_packet got;
        t_gate_event  seen;
        if (i_rst_n) begin
            if (pkt.valid && pkt.ready) begin
                got.forward = pkt.out_forward;
                got.lateral = pkt.out_lateral;
                got.yaw     = pkt.out_yaw;
                got.seq_num = pkt.packet_sequence;
                got.cause   = t_cause'(pkt.send_cause);
                sb.check_packet(got);
            end
            if (evt.valid && evt.ready) begin
                seen.action         = t_action'(evt.action);
                seen.forward        = evt.cmd_forward;
                seen.lateral        = evt.cmd_lateral;
                seen.yaw            = evt.cmd_yaw;
                seen.forward_finite = evt.forward_finite;
                seen.lateral_finite = evt.lateral_finite;
                seen.yaw_finite     = evt.yaw_finite;
                seen.level          = evt.battery_level;
                seen.level_finite   = evt.battery_finite;
                sb.note_event(seen);
            end
        end
    end

    // Hard limit on the length of the run.
    initial begin : run_limit
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("velocity_command_safety_gate_core verification failed");
        $finish;
    end

    initial begin : stimulus
        t_cfg   directed;
        t_phase plan[8];
        sb = new();
        plan = '{PH_GUARDED, PH_OPEN, PH_CLOSED, PH_ZERO_LIMIT,
                 PH_HIGH_FLOOR, PH_EDGE, PH_MAX, PH_WILD};
        sender_steady      = 1'b0;
        sink_steady        = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        evt.valid          = 1'b0;
        evt.action         = ACT_COMMAND;
        evt.cmd_forward    = '0;
        evt.cmd_lateral    = '0;
        evt.cmd_yaw        = '0;
        evt.forward_finite = 1'b0;
        evt.lateral_finite = 1'b0;
        evt.yaw_finite     = 1'b0;
        evt.battery_level  = '0;
        evt.battery_finite = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Out of reset the gate is closed: a command is blocked, a tick with
        // no motion is silent, and a shutdown always sends.
        push_event(command_item(1000, -1000, 500, 3'b111));
        push_event(noise_event(ACT_TICK));
        push_event(noise_event(ACT_SHUTDOWN));

        directed.gate_enable      = 1'b1;
        directed.battery_required = 1'b1;
        directed.limit_forward    = RST_LIMIT_FORWARD;
        directed.limit_lateral    = RST_LIMIT_LATERAL;
        directed.limit_yaw        = RST_LIMIT_YAW;
        directed.battery_floor    = RST_BATTERY_FLOOR;
        directed.battery_timeout  = TIMEOUT_W'(6);
        directed.command_timeout  = TIMEOUT_W'(3);
        apply_settings(directed);

        // No battery seen yet, so the command is still blocked.
        push_event(command_item(100, 100, 100, 3'b111));
        // A full battery is good; then the field extremes clamp both ways.
        push_event(battery_item(4096, 1'b1));
        push_event(command_item(VEL_MAX, VEL_MAX, VEL_MAX, 3'b111));
        push_event(command_item(VEL_MIN, VEL_MIN, VEL_MIN, 3'b111));
        // Non-finite axes become zero and an all-zero packet still forwards.
        push_event(command_item(VEL_MAX, VEL_MIN, VEL_MAX, 3'b000));
        push_event(command_item(410, -205, -819, 3'b111));
        // Just above full while moving sends the low battery packet.
        push_event(battery_item(4097, 1'b1));
        push_event(battery_item(818, 1'b1));
        push_event(battery_item(2000, 1'b0));
        push_event(battery_item(819, 1'b1));
        push_event(command_item(-411, 206, 0, 3'b111));
        // The fourth tick finds the command stale.
        repeat (4) push_event(noise_event(ACT_TICK));
        push_event(command_item(0, 0, 0, 3'b111));
        push_event(battery_item(8191, 1'b1));
        push_event(command_item(5, 5, 5, 3'b111));
        push_event(noise_event(ACT_SHUTDOWN));
        // A non-finite report while moving counts as low battery.
        push_event(battery_item(2000, 1'b1));
        push_event(command_item(1, -1, 1, 3'b111));
        push_event(battery_item(2000, 1'b0));

        foreach (plan[i]) run_phase(plan[i]);

        drain_events();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.failures == 0) begin
            $display("velocity_command_safety_gate_core verification clean");
        end else begin
            $display("velocity_command_safety_gate_core verification failed");
        end
        $finish;
    end

endmodule
